// ===== rtl/lgrsp_pkg.sv =====
// Shared types and constants for the two-gun light-gun pad.
// Used by lgrsp_aim, light_gun_raster_serial_pad_core and the bench; depends on nothing else.
package lgrsp_pkg;

  // Item modes
  localparam logic [1:0] MODE_TICK   = 2'd0;
  localparam logic [1:0] MODE_LATCH  = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // Configuration register indexes
  localparam logic CFG_CHAINED  = 1'b0;
  localparam logic CFG_OVERSCAN = 1'b1;

  // Beam geometry
  localparam int unsigned BEAM_W        = 19;
  localparam int unsigned DOTS_PER_LINE = 1364;
  localparam int unsigned X_OFFSET      = 24;
  localparam logic [8:0]  LINES_NORMAL   = 9'd225;
  localparam logic [8:0]  LINES_OVERSCAN = 9'd240;

  // Aim position limits and start values
  localparam logic signed [10:0] POS_MIN = -11'sd16;
  localparam logic signed [10:0] X_MAX   = 11'sd272;
  localparam logic signed [10:0] Y_MAX   = 11'sd256;
  localparam logic signed [9:0]  GUN1_X_SOLO  = 10'sd128;
  localparam logic signed [9:0]  GUN1_X_CHAIN = 10'sd112;
  localparam logic signed [9:0]  GUN2_X_CHAIN = 10'sd144;
  localparam logic signed [9:0]  GUN_Y_START  = 10'sd120;
  localparam logic signed [9:0]  GUN_PARKED   = -10'sd1;

  typedef struct packed {
    logic [1:0]        mode;
    logic              latch_level;
    logic [8:0]        beam_line;
    logic [10:0]       beam_dot;
    logic signed [7:0] aim1_dx;
    logic signed [7:0] aim1_dy;
    logic signed [7:0] aim2_dx;
    logic signed [7:0] aim2_dy;
    logic              trig1_in;
    logic              start1_in;
    logic              trig2_in;
    logic              start2_in;
  } lgrsp_in_t;

  typedef struct packed {
    logic serial_bit;
    logic raster_strobe;
  } lgrsp_out_t;

  // One beat of beam work handed to the aim unit
  typedef struct packed {
    logic              tick;
    logic [8:0]        line;
    logic [10:0]       dot;
    logic signed [7:0] d1x;
    logic signed [7:0] d1y;
    logic signed [7:0] d2x;
    logic signed [7:0] d2y;
    logic              active_gun;
  } lgrsp_aim_cmd_t;

  typedef struct packed {
    logic chained;
    logic overscan;
    logic reinit;
    logic reinit_chained;
  } lgrsp_aim_ctl_t;

  // Add a signed delta to a position and clamp it to POS_MIN..hi.
  function automatic logic signed [9:0] clamp_add(input logic signed [9:0] pos,
                                                  input logic signed [7:0] d,
                                                  input logic signed [10:0] hi);
    logic signed [10:0] s;
    logic signed [10:0] r;
    s = $signed({pos[9], pos}) + $signed({{3{d[7]}}, d});
    if (s < POS_MIN) r = POS_MIN;
    else if (s > hi) r = hi;
    else r = s;
    return r[9:0];
  endfunction

endpackage

// ===== rtl/lgrsp_aim.sv =====
// Aim unit: holds both gun positions and the previous beam position, raises the
// raster strobe and applies aim deltas on frame wrap. Depends on lgrsp_pkg.
module lgrsp_aim (
  input  logic                      clk,
  input  logic                      rst_n,
  input  lgrsp_pkg::lgrsp_aim_cmd_t cmd,
  input  lgrsp_pkg::lgrsp_aim_ctl_t ctl,
  output logic                      strobe
);
  import lgrsp_pkg::*;

  logic [BEAM_W-1:0] prev_beam_r, prev_beam_nxt;
  logic signed [9:0] gun1_x_r, gun1_y_r, gun2_x_r, gun2_y_r;
  logic signed [9:0] gun1_x_nxt, gun1_y_nxt, gun2_x_nxt, gun2_y_nxt;

  logic [19:0]       beam_full;
  logic [BEAM_W-1:0] next_beam;
  logic signed [9:0] aim_x, aim_y;
  logic [8:0]        lines;
  logic              on_screen;
  logic [8:0]        x_shifted;
  logic [BEAM_W-1:0] target;
  logic              wrap;

  assign beam_full = 20'(cmd.line) * 20'(DOTS_PER_LINE) + 20'(cmd.dot);
  assign next_beam = beam_full[BEAM_W-1:0];

  assign aim_x = cmd.active_gun ? gun2_x_r : gun1_x_r;
  assign aim_y = cmd.active_gun ? gun2_y_r : gun1_y_r;
  assign lines = ctl.overscan ? LINES_OVERSCAN : LINES_NORMAL;

  // Non-negative and below 256 means the top two bits are clear.
  assign on_screen = (aim_x[9:8] == 2'b00) && !aim_y[9] && (aim_y[8:0] < lines);
  assign x_shifted = 9'(aim_x[7:0]) + 9'(X_OFFSET);
  assign target    = BEAM_W'(aim_y[8:0]) * BEAM_W'(DOTS_PER_LINE)
                   + BEAM_W'({x_shifted, 2'b00});

  assign strobe = cmd.tick && on_screen && (next_beam >= target) && (prev_beam_r < target);
  assign wrap   = cmd.tick && (next_beam < prev_beam_r);

  always_comb begin
    prev_beam_nxt = prev_beam_r;
    gun1_x_nxt    = gun1_x_r;
    gun1_y_nxt    = gun1_y_r;
    gun2_x_nxt    = gun2_x_r;
    gun2_y_nxt    = gun2_y_r;
    if (ctl.reinit) begin
      gun1_x_nxt = ctl.reinit_chained ? GUN1_X_CHAIN : GUN1_X_SOLO;
      gun1_y_nxt = GUN_Y_START;
      gun2_x_nxt = ctl.reinit_chained ? GUN2_X_CHAIN : GUN_PARKED;
      gun2_y_nxt = ctl.reinit_chained ? GUN_Y_START : GUN_PARKED;
    end else if (cmd.tick) begin
      prev_beam_nxt = next_beam;
      if (wrap) begin
        gun1_x_nxt = clamp_add(gun1_x_r, cmd.d1x, X_MAX);
        gun1_y_nxt = clamp_add(gun1_y_r, cmd.d1y, Y_MAX);
        if (ctl.chained) begin
          gun2_x_nxt = clamp_add(gun2_x_r, cmd.d2x, X_MAX);
          gun2_y_nxt = clamp_add(gun2_y_r, cmd.d2y, Y_MAX);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_beam_r <= '0;
      gun1_x_r    <= GUN1_X_SOLO;
      gun1_y_r    <= GUN_Y_START;
      gun2_x_r    <= GUN_PARKED;
      gun2_y_r    <= GUN_PARKED;
    end else begin
      prev_beam_r <= prev_beam_nxt;
      gun1_x_r    <= gun1_x_nxt;
      gun1_y_r    <= gun1_y_nxt;
      gun2_x_r    <= gun2_x_nxt;
      gun2_y_r    <= gun2_y_nxt;
    end
  end

  a_gun1_x_range: assert property (@(posedge clk) disable iff (!rst_n)
    (11'(gun1_x_r) >= POS_MIN) && (11'(gun1_x_r) <= X_MAX))
    else $error("gun1 x out of range");

  a_gun1_y_range: assert property (@(posedge clk) disable iff (!rst_n)
    (11'(gun1_y_r) >= POS_MIN) && (11'(gun1_y_r) <= Y_MAX))
    else $error("gun1 y out of range");

  a_gun2_parked: assert property (@(posedge clk) disable iff (!rst_n)
    !ctl.chained && !ctl.reinit |-> (gun2_x_r == GUN_PARKED) && (gun2_y_r == GUN_PARKED))
    else $error("unchained second gun has moved");

endmodule

// ===== rtl/light_gun_raster_serial_pad_core.sv =====
// Top level of the two-gun light-gun pad: input register, serial report logic,
// result register. Depends on lgrsp_pkg and lgrsp_aim.
//
//   channel  direction  handshake          payload
//   in_      in         in_valid/in_ready  lgrsp_in_t  (mode, beam, aims, buttons)
//   out_     out        out_valid/out_ready lgrsp_out_t (serial_bit, raster_strobe)
//   cfg_     in         cfg_we             cfg_index, cfg_data
//
// Every item yields one result, held first in the input register and then in the result register;
// one beat a cycle is sustained while the result side does not stall.
// Reset is synchronous and active low and empties both registers.
// A stall on the result side holds the result register, then the input register;
// in_ready drops only once both are full.
module light_gun_raster_serial_pad_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  lgrsp_pkg::lgrsp_in_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output lgrsp_pkg::lgrsp_out_t out_data,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic                  cfg_data
);
  import lgrsp_pkg::*;

  logic           s1_valid_r, s1_valid_nxt;
  lgrsp_in_t      s1_data_r;
  logic           out_valid_r, out_valid_nxt;
  lgrsp_out_t     out_data_r;

  logic           chained_r, chained_nxt;
  logic           overscan_r, overscan_nxt;
  logic [3:0]     button_latch_r, button_latch_nxt;
  logic [5:0]     bit_count_r, bit_count_nxt;
  logic           latch_state_r, latch_state_nxt;
  logic           active_gun_r, active_gun_nxt;

  logic           adv;
  logic           latch_change;
  logic           sbit;
  logic           strobe;
  lgrsp_aim_cmd_t aim_cmd;
  lgrsp_aim_ctl_t aim_ctl;

  function automatic logic report_bit(input logic [4:0] n, input logic [3:0] bl,
                                      input logic ag);
    logic r;
    priority if (n < 5'd12) r = 1'b0;
    else if (n < 5'd15) r = 1'b1;
    else if (n < 5'd24) r = (n >= 5'd16) && n[0];
    else begin
      unique case (n)
        5'd24:   r = bl[0];
        5'd25:   r = bl[1];
        5'd26:   r = bl[2];
        5'd27:   r = bl[3];
        5'd28:   r = ag;
        default: r = 1'b0;
      endcase
    end
    return r;
  endfunction

  // The held item moves on whenever the result register is free or being drained.
  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;

  assign s1_valid_nxt  = (in_valid && in_ready) || (s1_valid_r && !adv);
  assign out_valid_nxt = adv || (out_valid_r && !out_ready);

  assign aim_cmd.tick       = adv && (s1_data_r.mode == MODE_TICK);
  assign aim_cmd.line       = s1_data_r.beam_line;
  assign aim_cmd.dot        = s1_data_r.beam_dot;
  assign aim_cmd.d1x        = s1_data_r.aim1_dx;
  assign aim_cmd.d1y        = s1_data_r.aim1_dy;
  assign aim_cmd.d2x        = s1_data_r.aim2_dx;
  assign aim_cmd.d2y        = s1_data_r.aim2_dy;
  assign aim_cmd.active_gun = active_gun_r;

  assign aim_ctl.chained        = chained_r;
  assign aim_ctl.overscan       = overscan_r;
  assign aim_ctl.reinit         = cfg_we && (cfg_index == CFG_CHAINED);
  assign aim_ctl.reinit_chained = cfg_data;

  lgrsp_aim u_aim (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (aim_cmd),
    .ctl    (aim_ctl),
    .strobe (strobe)
  );

  assign latch_change = adv && (s1_data_r.mode == MODE_LATCH)
                     && (s1_data_r.latch_level != latch_state_r);

  always_comb begin
    chained_nxt      = chained_r;
    overscan_nxt     = overscan_r;
    button_latch_nxt = button_latch_r;
    bit_count_nxt    = bit_count_r;
    latch_state_nxt  = latch_state_r;
    active_gun_nxt   = active_gun_r;
    sbit             = 1'b0;

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_CHAINED:  chained_nxt  = cfg_data;
        CFG_OVERSCAN: overscan_nxt = cfg_data;
        default:      ;
      endcase
    end

    if (latch_change) begin
      latch_state_nxt = s1_data_r.latch_level;
      bit_count_nxt   = '0;
      if (!s1_data_r.latch_level) active_gun_nxt = !active_gun_r;
    end

    if (adv && (s1_data_r.mode == MODE_READ)) begin
      if (bit_count_r[5]) begin
        // Past the end of the report every read returns one.
        sbit = 1'b1;
      end else begin
        if (bit_count_r == 6'd0) begin
          button_latch_nxt[0] = s1_data_r.trig1_in;
          button_latch_nxt[2] = s1_data_r.start1_in;
          if (chained_r) begin
            button_latch_nxt[1] = s1_data_r.trig2_in;
            button_latch_nxt[3] = s1_data_r.start2_in;
          end
        end
        sbit          = report_bit(bit_count_r[4:0], button_latch_r, active_gun_r);
        bit_count_nxt = bit_count_r + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      chained_r      <= 1'b0;
      overscan_r     <= 1'b0;
      button_latch_r <= '0;
      bit_count_r    <= '0;
      latch_state_r  <= 1'b0;
      active_gun_r   <= 1'b0;
    end else begin
      s1_valid_r     <= s1_valid_nxt;
      out_valid_r    <= out_valid_nxt;
      chained_r      <= chained_nxt;
      overscan_r     <= overscan_nxt;
      button_latch_r <= button_latch_nxt;
      bit_count_r    <= bit_count_nxt;
      latch_state_r  <= latch_state_nxt;
      active_gun_r   <= active_gun_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) s1_data_r <= in_data;
    if (adv) begin
      out_data_r.serial_bit    <= sbit;
      out_data_r.raster_strobe <= strobe;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bit_count_r <= 6'd32)
    else $error("bit counter beyond report length");

  a_latch_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    latch_change |=> (bit_count_r == 6'd0))
    else $error("latch change did not restart the report");

  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> !(out_data_r.serial_bit && out_data_r.raster_strobe))
    else $error("strobe and report bit in the same beat");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !adv |=> s1_valid_r && $stable(s1_data_r))
    else $error("held item lost while stalled");

endmodule

// ===== bench/light_gun_raster_serial_pad_core_tb.sv =====
// Self-checking bench for light_gun_raster_serial_pad_core: directed and random beats
// checked against a cycle-free mirror of the pad held in the bench itself.
// Depends on lgrsp_pkg and the RTL of the pad.
module light_gun_raster_serial_pad_core_tb;
  import lgrsp_pkg::*;

  localparam int SCREEN_W   = 256;
  localparam int BEAM_WRAP  = 1 << BEAM_W;
  localparam int LAST_BEAM  = 311 * 1364 + 1363;
  localparam int TIMEOUT_TU = 3_000_000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  lgrsp_in_t  in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  lgrsp_out_t out_data;
  logic       cfg_we = 1'b0;
  logic       cfg_index = 1'b0;
  logic       cfg_data = 1'b0;

  light_gun_raster_serial_pad_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Mirror of the pad state
  logic       m_chained, m_overscan;
  int         m_prev_beam;
  int         m_g1x, m_g1y, m_g2x, m_g2y;
  logic [3:0] m_buttons;
  int         m_bit_count;
  logic       m_latch, m_active;

  lgrsp_out_t pad_out_q[$];
  int         mismatch_count = 0;
  int         burst_left = 0;
  bit         sender_idles = 1'b1;

  function automatic int clip(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic logic report_bit(int n, logic [3:0] btn, logic act);
    if (n < 12) return 1'b0;
    if (n < 15) return 1'b1;
    if (n < 24) return (n >= 16) && (n % 2 == 1);
    case (n)
      24: return btn[0];
      25: return btn[1];
      26: return btn[2];
      27: return btn[3];
      28: return act;
      default: return 1'b0;
    endcase
  endfunction

  task automatic place_guns();
    if (m_chained) begin
      m_g1x = int'(GUN1_X_CHAIN); m_g1y = int'(GUN_Y_START);
      m_g2x = int'(GUN2_X_CHAIN); m_g2y = int'(GUN_Y_START);
    end else begin
      m_g1x = int'(GUN1_X_SOLO);  m_g1y = int'(GUN_Y_START);
      m_g2x = int'(GUN_PARKED);   m_g2y = int'(GUN_PARKED);
    end
  endtask

  // Beam position at which the active gun would fire, or -1 when off screen.
  function automatic int aim_target();
    int x, y, lines;
    x = m_active ? m_g2x : m_g1x;
    y = m_active ? m_g2y : m_g1y;
    lines = m_overscan ? int'(LINES_OVERSCAN) : int'(LINES_NORMAL);
    if (x < 0 || y < 0 || x >= SCREEN_W || y >= lines) return -1;
    return y * int'(DOTS_PER_LINE) + (x + int'(X_OFFSET)) * 4;
  endfunction

  // Advance the mirror by one accepted beat and queue the result it gives.
  task automatic mirror_pad_step(input lgrsp_in_t it);
    lgrsp_out_t r;
    int nxt, tgt;
    r = '0;
    case (it.mode)
      MODE_TICK: begin
        nxt = (int'(it.beam_line) * int'(DOTS_PER_LINE) + int'(it.beam_dot)) % BEAM_WRAP;
        tgt = aim_target();
        if (tgt >= 0 && nxt >= tgt && m_prev_beam < tgt) r.raster_strobe = 1'b1;
        if (nxt < m_prev_beam) begin
          m_g1x = clip(m_g1x + int'($signed(it.aim1_dx)), int'(POS_MIN), int'(X_MAX));
          m_g1y = clip(m_g1y + int'($signed(it.aim1_dy)), int'(POS_MIN), int'(Y_MAX));
          if (m_chained) begin
            m_g2x = clip(m_g2x + int'($signed(it.aim2_dx)), int'(POS_MIN), int'(X_MAX));
            m_g2y = clip(m_g2y + int'($signed(it.aim2_dy)), int'(POS_MIN), int'(Y_MAX));
          end
        end
        m_prev_beam = nxt;
      end
      MODE_LATCH: begin
        if (it.latch_level != m_latch) begin
          m_latch = it.latch_level;
          m_bit_count = 0;
          if (!it.latch_level) m_active = ~m_active;
        end
      end
      MODE_READ: begin
        if (m_bit_count >= 32) begin
          r.serial_bit = 1'b1;
        end else begin
          if (m_bit_count == 0) begin
            m_buttons[0] = it.trig1_in;
            m_buttons[2] = it.start1_in;
            if (m_chained) begin
              m_buttons[1] = it.trig2_in;
              m_buttons[3] = it.start2_in;
            end
          end
          r.serial_bit = report_bit(m_bit_count, m_buttons, m_active);
          m_bit_count++;
        end
      end
      default: ;
    endcase
    pad_out_q.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Each result beat is checked against the oldest queued expectation.
  always @(posedge clk) begin
    lgrsp_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pad_out_q.size() == 0) begin
        report_mismatch("unexpected result beat", 1, 0);
      end else begin
        want = pad_out_q.pop_front();
        if (out_data.serial_bit !== want.serial_bit)
          report_mismatch("serial_bit", out_data.serial_bit, want.serial_bit);
        if (out_data.raster_strobe !== want.raster_strobe)
          report_mismatch("raster_strobe", out_data.raster_strobe, want.raster_strobe);
      end
    end
  end

  // The receiver stalls on a 16-bit pattern that is redrawn whenever the low byte of rx_cycle is zero.
  int unsigned rx_cycle = 0;
  logic [15:0] rx_pattern = 16'hFFFF;
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle[7:0] == 8'd0) begin
      if ($urandom_range(0, 3) == 0) rx_pattern <= 16'hFFFF;
      else rx_pattern <= 16'($urandom) | 16'h0001;
    end
    out_ready <= rx_pattern[rx_cycle[3:0]];
  end

  task automatic send_item(input lgrsp_in_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = sender_idles ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    mirror_pad_step(it);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pad_out_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // The trailing edge keeps the next write from landing in the same time step.
  task automatic write_reg(input logic idx, input logic val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_CHAINED) begin
      m_chained = val;
      place_guns();
    end else begin
      m_overscan = val;
    end
    @(posedge clk);
  endtask

  function automatic logic [7:0] rand_delta();
    case ($urandom_range(0, 7))
      0: return 8'h80;
      1: return 8'h7F;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic lgrsp_in_t noise_item();
    lgrsp_in_t it;
    it = lgrsp_in_t'({$urandom, $urandom, $urandom});
    it.aim1_dx = rand_delta();
    it.aim1_dy = rand_delta();
    it.aim2_dx = rand_delta();
    it.aim2_dy = rand_delta();
    return it;
  endfunction

  function automatic lgrsp_in_t tick_at(int pos);
    lgrsp_in_t it;
    it = noise_item();
    it.mode      = MODE_TICK;
    it.beam_line = 9'(pos / int'(DOTS_PER_LINE));
    it.beam_dot  = 11'(pos % int'(DOTS_PER_LINE));
    return it;
  endfunction

  function automatic lgrsp_in_t latch_item(logic lvl);
    lgrsp_in_t it;
    it = noise_item();
    it.mode = MODE_LATCH;
    it.latch_level = lvl;
    return it;
  endfunction

  function automatic lgrsp_in_t read_item();
    lgrsp_in_t it;
    it = noise_item();
    it.mode = MODE_READ;
    return it;
  endfunction

  function automatic lgrsp_in_t tick_raw(logic [8:0] line, logic [10:0] dot,
                                         logic [7:0] d);
    lgrsp_in_t it;
    it = noise_item();
    it.mode = MODE_TICK;
    it.beam_line = line;
    it.beam_dot = dot;
    it.aim1_dx = d; it.aim1_dy = d; it.aim2_dx = d; it.aim2_dy = d;
    return it;
  endfunction

  // Beam corners, the modulo wrap of an oversized position and both clamp limits.
  task automatic test_beam_extremes();
    send_item(tick_raw(9'd0,   11'd0,    8'h00));
    send_item(tick_raw(9'd120, 11'd608,  8'h00));
    send_item(tick_raw(9'd311, 11'd1363, 8'h00));
    send_item(tick_raw(9'h1FF, 11'h7FF,  8'h80));
    send_item(tick_raw(9'd0,   11'd0,    8'h80));
    send_item(tick_raw(9'd300, 11'd0,    8'h00));
    send_item(tick_raw(9'd0,   11'd0,    8'h7F));
    send_item(tick_raw(9'd300, 11'd0,    8'h00));
    send_item(tick_raw(9'd0,   11'd0,    8'h7F));
    send_item(tick_raw(9'd300, 11'd0,    8'h00));
    send_item(tick_raw(9'd0,   11'd0,    8'h7F));
  endtask

  // Latch at the same level, the falling-edge gun swap and the unused mode.
  task automatic test_latch_and_unused_mode();
    lgrsp_in_t it;
    send_item(latch_item(1'b1));
    send_item(latch_item(1'b1));
    it = read_item();
    {it.trig1_in, it.start1_in, it.trig2_in, it.start2_in} = 4'hF;
    send_item(it);
    send_item(read_item());
    send_item(latch_item(1'b0));
    it = noise_item();
    it.mode = MODE_UNUSED;
    send_item(it);
  endtask

  // Second-gun buttons are sampled only when chained; overscan allows lower aim.
  task automatic test_chained_pad();
    lgrsp_in_t it;
    wait_idle();
    write_reg(CFG_CHAINED, 1'b1);
    write_reg(CFG_OVERSCAN, 1'b1);
    send_item(latch_item(1'b1));
    it = read_item();
    {it.trig1_in, it.start1_in, it.trig2_in, it.start2_in} = 4'b0101;
    send_item(it);
    send_item(tick_raw(9'd0,   11'd0,   8'h00));
    send_item(tick_raw(9'd120, 11'd800, 8'h00));
    send_item(tick_raw(9'd0,   11'd0,   8'h7F));
    send_item(tick_raw(9'd250, 11'd0,   8'h00));
  endtask

  // One frame: rising beam positions, some landing on the aim point.
  task automatic frame_sweep(inout int sent);
    int pos, tgt, k, n;
    n = $urandom_range(4, 16);
    pos = $urandom_range(0, 3000);
    for (k = 0; k < n && pos <= LAST_BEAM; k++) begin
      tgt = aim_target();
      if (tgt > m_prev_beam && $urandom_range(0, 2) == 0) pos = tgt + $urandom_range(0, 2);
      send_item(tick_at(pos));
      sent++;
      pos += $urandom_range(1, 60000);
    end
  endtask

  // Usually a latch pulse, then a report read out partly or in full, sometimes past its end.
  task automatic report_sequence(inout int sent);
    int k, n;
    if ($urandom_range(0, 4) != 0) begin
      send_item(latch_item(1'b1));
      send_item(latch_item(1'b0));
      sent += 2;
    end
    n = $urandom_range(0, 3) == 0 ? $urandom_range(1, 20) : $urandom_range(29, 36);
    for (k = 0; k < n; k++) begin
      send_item(read_item());
      sent++;
    end
  endtask

  task automatic test_random_phases();
    int phase, sent, pick;
    logic ch, ov;
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: {ch, ov} = 2'b00;
        1: {ch, ov} = 2'b11;
        2: {ch, ov} = 2'b10;
        3: {ch, ov} = 2'b01;
        default: {ch, ov} = 2'($urandom);
      endcase
      wait_idle();
      write_reg(CFG_CHAINED, ch);
      write_reg(CFG_OVERSCAN, ov);
      sender_idles = (phase % 3) != 2;
      sent = 0;
      while (sent < 55) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          frame_sweep(sent);
        end else if (pick < 80) begin
          report_sequence(sent);
        end else begin
          send_item(noise_item());
          sent++;
        end
      end
    end
  endtask

  initial begin
    m_chained = 1'b0;
    m_overscan = 1'b0;
    m_prev_beam = 0;
    place_guns();
    m_buttons = '0;
    m_bit_count = 0;
    m_latch = 1'b0;
    m_active = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_beam_extremes();
    test_latch_and_unused_mode();
    test_chained_pad();
    test_random_phases();
    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_TU);
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/lgrsp_pkg.sv
rtl/lgrsp_aim.sv
rtl/light_gun_raster_serial_pad_core.sv
bench/light_gun_raster_serial_pad_core_tb.sv
